FILE: hw/rtl/irpw_pkg.sv
// Shared types, constants and window-check helper for the IR pulse width receiver.
// No dependencies; imported by every other file but the stream interface.

package irpw_pkg;

	localparam int unsigned TICK_W    = 16;
	localparam int unsigned CFG_IDX_W = 3;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER = 3'd0,
		REG_ONE    = 3'd1,
		REG_ZERO   = 3'd2,
		REG_SPACE  = 3'd3,
		REG_MARGIN = 3'd4
	} cfg_reg_t;

	// Register values after reset
	localparam logic [TICK_W-1:0] HEADER_RST = 16'd38400;
	localparam logic [TICK_W-1:0] ONE_RST    = 16'd19200;
	localparam logic [TICK_W-1:0] ZERO_RST   = 16'd9600;
	localparam logic [TICK_W-1:0] SPACE_RST  = 16'd9600;
	localparam logic [TICK_W-1:0] MARGIN_RST = 16'd2400;

	// Bit assembly constants
	localparam logic [7:0] MASK_INIT = 8'h80;
	localparam logic [4:0] MSG_BITS  = 5'd24;
	localparam logic [4:0] SHOT_BITS = 5'd14;

	typedef struct packed {
		logic [TICK_W-1:0] header_ticks;
		logic [TICK_W-1:0] one_ticks;
		logic [TICK_W-1:0] zero_ticks;
		logic [TICK_W-1:0] space_ticks;
		logic [TICK_W-1:0] margin_ticks;
	} cfg_t;

	// Input beat: one line edge or a timer overflow
	typedef struct packed {
		logic              func;
		logic              level;
		logic [TICK_W-1:0] elapsed;
	} evt_t;

	// Output beat: one received byte
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       packet_end;
		logic       is_message;
	} rx_t;

	// Core status seen by the top level checks
	typedef struct packed {
		logic step;
		logic func;
		logic emit;
		logic last;
		logic idle;
		logic timer_on;
	} stat_t;

	// Strict window: nom - margin < t < nom + margin, evaluated without wrap
	function automatic logic in_window(input logic [TICK_W-1:0] t,
			input logic [TICK_W-1:0] nom, input logic [TICK_W-1:0] margin);
		logic [TICK_W:0] lo_sum;
		logic [TICK_W:0] hi_sum;
		lo_sum = {1'b0, t} + {1'b0, margin};
		hi_sum = {1'b0, nom} + {1'b0, margin};
		return (lo_sum > {1'b0, nom}) && ({1'b0, t} < hi_sum);
	endfunction

endpackage

FILE: hw/rtl/irpw_stream_if.sv
// Valid/ready stream interface used for the event and byte channels.
// The payload type is given by the instantiating module (see irpw_pkg types).

interface irpw_stream_if #(parameter type payload_t = logic);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

FILE: hw/rtl/irpw_cfg_regs.sv
// Timing window register bank of the IR pulse width receiver.
// Depends on irpw_pkg for register indexes, reset values and cfg_t.

module irpw_cfg_regs import irpw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Write one register per enabled cycle; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_ticks <= HEADER_RST;
			cfg_q.one_ticks    <= ONE_RST;
			cfg_q.zero_ticks   <= ZERO_RST;
			cfg_q.space_ticks  <= SPACE_RST;
			cfg_q.margin_ticks <= MARGIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER: cfg_q.header_ticks <= cfg_wdata;
				REG_ONE:    cfg_q.one_ticks    <= cfg_wdata;
				REG_ZERO:   cfg_q.zero_ticks   <= cfg_wdata;
				REG_SPACE:  cfg_q.space_ticks  <= cfg_wdata;
				REG_MARGIN: cfg_q.margin_ticks <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/irpw_core.sv
// Decoder core: input register, pulse window checks, bit assembly, result register.
// Depends on irpw_pkg and irpw_stream_if.

module irpw_core import irpw_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	irpw_stream_if.sink     evt,
	irpw_stream_if.source   rx,
	output stat_t           st
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_DATA,
		PH_SPACE
	} phase_t;

	// Input stage
	evt_t evt_s1;
	logic evt_valid_s1;

	// Receiver state
	phase_t     phase_q;
	logic       timer_q;
	logic [7:0] accum_q;
	logic [7:0] mask_q;
	logic [4:0] left_q;
	logic       kind_q;

	// Result register
	rx_t  res_q;
	logic res_valid_q;

	// Next-state values
	phase_t            phase_d;
	logic              timer_d;
	logic [7:0]        accum_d;
	logic [7:0]        mask_d;
	logic [4:0]        left_d;
	logic              kind_d;
	logic [7:0]        accum_new;
	logic [7:0]        mask_new;
	logic [4:0]        left_start;
	logic [TICK_W-1:0] t;
	logic              win_hdr;
	logic              win_sp;
	logic              win_one;
	logic              win_zero;
	logic              abort;
	logic              emit;
	logic              last;
	logic              step;

	// Elapsed time reads as zero while the timer is stopped
	assign t = timer_q ? evt_s1.elapsed : '0;

	assign win_hdr  = in_window(t, cfg.header_ticks, cfg.margin_ticks);
	assign win_sp   = in_window(t, cfg.space_ticks, cfg.margin_ticks);
	assign win_one  = in_window(t, cfg.one_ticks, cfg.margin_ticks);
	assign win_zero = in_window(t, cfg.zero_ticks, cfg.margin_ticks);

	// Decode one event against the current phase
	always_comb begin
		phase_d    = phase_q;
		timer_d    = timer_q;
		accum_d    = accum_q;
		mask_d     = mask_q;
		left_d     = left_q;
		kind_d     = kind_q;
		accum_new  = accum_q;
		mask_new   = mask_q;
		left_start = left_q;
		abort      = 1'b0;
		emit       = 1'b0;
		last       = 1'b0;
		if (evt_s1.func) begin
			abort = 1'b1;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (evt_s1.level) begin
						if (win_hdr) begin
							accum_d = '0;
							mask_d  = MASK_INIT;
							left_d  = '0;
							phase_d = PH_HEADER;
						end else begin
							abort = 1'b1;
						end
					end else begin
						timer_d = 1'b1;
					end
				end
				PH_HEADER, PH_DATA: begin
					if (!evt_s1.level && win_sp) begin
						phase_d = PH_SPACE;
					end else begin
						abort = 1'b1;
					end
				end
				PH_SPACE: begin
					if (!evt_s1.level || (!win_one && !win_zero)) begin
						abort = 1'b1;
					end else begin
						// one window wins where the two overlap
						accum_new = win_one ? (accum_q | mask_q) : accum_q;
						mask_new  = mask_q >> 1;
						// first bit of a packet picks its length
						if (left_q == '0) begin
							kind_d     = accum_new[7];
							left_start = accum_new[7] ? MSG_BITS : SHOT_BITS;
						end
						left_d  = left_start - 5'd1;
						last    = (left_d == '0);
						phase_d = last ? PH_IDLE : PH_DATA;
						emit    = (mask_new == '0) || last;
						accum_d = emit ? '0 : accum_new;
						mask_d  = emit ? MASK_INIT : mask_new;
					end
				end
				default: begin
					abort = 1'b1;
				end
			endcase
		end
		// Drop back to idle with the timer stopped
		if (abort) begin
			phase_d = PH_IDLE;
			timer_d = 1'b0;
			accum_d = '0;
			mask_d  = MASK_INIT;
			left_d  = '0;
		end
	end

	// Advance the held event unless its byte would overrun a full result register
	assign step      = evt_valid_s1 && (!emit || !res_valid_q || rx.ready);
	assign evt.ready = !evt_valid_s1 || step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			evt_valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			evt_s1 <= evt.payload;
		end
	end

	// Receiver state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			timer_q     <= 1'b0;
			accum_q     <= '0;
			mask_q      <= MASK_INIT;
			left_q      <= '0;
			kind_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= phase_d;
				timer_q <= timer_d;
				accum_q <= accum_d;
				mask_q  <= mask_d;
				left_q  <= left_d;
				kind_q  <= kind_d;
			end
			if (step && emit) begin
				res_valid_q <= 1'b1;
			end else if (rx.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Hold the byte beat until taken
	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_q.rx_byte    <= accum_new;
			res_q.packet_end <= last;
			res_q.is_message <= kind_d;
		end
	end

	assign rx.valid   = res_valid_q;
	assign rx.payload = res_q;

	assign st.step     = step;
	assign st.func     = evt_s1.func;
	assign st.emit     = emit;
	assign st.last     = last;
	assign st.idle     = (phase_q == PH_IDLE);
	assign st.timer_on = timer_q;

endmodule

FILE: hw/rtl/ir_pulse_width_receiver_unit.sv
// Top level of the IR pulse width receiver: register bank plus decoder core.
// Depends on irpw_pkg, irpw_stream_if, irpw_cfg_regs and irpw_core.

// Takes one edge or timer-overflow event per beat on evt and returns received
// bytes on rx, MSB first, with packet_end on the closing byte and is_message
// set for 24-bit packets (14-bit shot packets otherwise). An event is taken
// every clock cycle unless a byte-producing event waits on a full result
// register. The event that completes a byte is decoded out of the input
// register straight into the result register, which drives rx valid.
// The single result register sets the rate under back-pressure: while
// it holds an untaken byte, events that produce no byte still flow, and the
// next byte-producing event waits in the input register. Window registers are
// written through cfg_we/cfg_index/cfg_wdata and should only change while no
// packet is in flight.

module ir_pulse_width_receiver_unit import irpw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_wdata,
	irpw_stream_if.sink          evt,
	irpw_stream_if.source        rx
);

	cfg_t  cfg;
	stat_t st;

	irpw_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	irpw_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.evt    (evt),
		.rx     (rx),
		.st     (st)
	);

`ifndef NO_ASSERTIONS
	// An overflow event always leaves the receiver idle with the timer stopped
	a_overflow_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st.step && st.func |=> st.idle && !st.timer_on)
		else $error("overflow did not return the receiver to idle");

	// The closing byte of a packet returns the receiver to idle
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st.step && st.emit && st.last |=> st.idle)
		else $error("receiver not idle after packet end");

	// A new byte beat only follows a decoded event that produced one
	a_rx_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rx.valid) |-> $past(st.step && st.emit))
		else $error("byte beat without a completing event");

	// A byte beat that closes a packet comes from a step flagged as last
	a_end_flag: assert property (@(posedge clk) disable iff (!arst_n)
		st.step && st.emit |=> rx.valid && (rx.payload.packet_end == $past(st.last)))
		else $error("packet end flag mismatch");
`endif

endmodule

FILE: test/testbench.sv
// Self-checking bench for the IR pulse width receiver: directed edge table, then random packets.
// Depends on irpw_pkg, irpw_stream_if and ir_pulse_width_receiver_unit.
`timescale 1ns / 1ps

module testbench import irpw_pkg::*; ();

	localparam int CLK_HALF       = 4;
	localparam int RESET_CYCLES   = 12;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int PLAN_ROWS      = 26;

	// One row of the directed table; chk marks a byte read straight off the row
	typedef struct packed {
		logic              func;
		logic              level;
		logic [TICK_W-1:0] elapsed;
		logic              chk;
		logic [7:0]        want_byte;
		logic              want_end;
		logic              want_msg;
	} plan_row_t;

	localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
		'{1'b1, 1'b1, 16'hFFFF, 1'b0, 8'h00, 1'b0, 1'b0},  // overflow while idle
		'{1'b0, 1'b1, 16'hFFFF, 1'b0, 8'h00, 1'b0, 1'b0},  // mark end, timer stopped
		'{1'b0, 1'b0, 16'hFFFF, 1'b0, 8'h00, 1'b0, 1'b0},  // start the timer
		'{1'b0, 1'b1, 16'd38400, 1'b0, 8'h00, 1'b0, 1'b0}, // header
		'{1'b0, 1'b0, 16'd9600, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 1'b1, 16'd19200, 1'b0, 8'h00, 1'b0, 1'b0}, // 1: message packet
		'{1'b0, 1'b0, 16'd9600, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 1'b1, 16'd9600, 1'b0, 8'h00, 1'b0, 1'b0},  // 0
		'{1'b0, 1'b0, 16'd9600, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 1'b1, 16'd21599, 1'b0, 8'h00, 1'b0, 1'b0}, // 1, top of window
		'{1'b0, 1'b0, 16'd9600, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 1'b1, 16'd7201, 1'b0, 8'h00, 1'b0, 1'b0},  // 0, bottom of window
		'{1'b0, 1'b0, 16'd11999, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 1'b1, 16'd9600, 1'b0, 8'h00, 1'b0, 1'b0},  // 0
		'{1'b0, 1'b0, 16'd9600, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 1'b1, 16'd16801, 1'b0, 8'h00, 1'b0, 1'b0}, // 1
		'{1'b0, 1'b0, 16'd9600, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 1'b1, 16'd11999, 1'b0, 8'h00, 1'b0, 1'b0}, // 0
		'{1'b0, 1'b0, 16'd9600, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 1'b1, 16'd19200, 1'b1, 8'hA5, 1'b0, 1'b1}, // 1, first byte done
		'{1'b0, 1'b1, 16'd9600, 1'b0, 8'h00, 1'b0, 1'b0},  // rising where space expected
		'{1'b0, 1'b0, 16'd0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 1'b1, 16'd40800, 1'b0, 8'h00, 1'b0, 1'b0}, // header at upper bound
		'{1'b0, 1'b0, 16'd0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{1'b0, 1'b1, 16'd36001, 1'b0, 8'h00, 1'b0, 1'b0}, // header just inside
		'{1'b1, 1'b0, 16'd9600, 1'b0, 8'h00, 1'b0, 1'b0}   // overflow mid-packet
	};

	typedef enum logic [1:0] {
		RX_IDLE,
		RX_HEADER,
		RX_DATA,
		RX_SPACE
	} rx_phase_e;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_wdata;

	irpw_stream_if #(.payload_t(evt_t)) evt_ch ();
	irpw_stream_if #(.payload_t(rx_t))  byte_ch ();

	ir_pulse_width_receiver_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.evt       (evt_ch),
		.rx        (byte_ch)
	);

	// Decoder mirror: window registers and receive state
	logic [TICK_W-1:0] w_header = HEADER_RST;
	logic [TICK_W-1:0] w_one    = ONE_RST;
	logic [TICK_W-1:0] w_zero   = ZERO_RST;
	logic [TICK_W-1:0] w_space  = SPACE_RST;
	logic [TICK_W-1:0] w_margin = MARGIN_RST;

	rx_phase_e  m_phase = RX_IDLE;
	logic       m_timer = 1'b0;
	logic [7:0] m_acc   = 8'h00;
	logic [7:0] m_mask  = MASK_INIT;
	logic [4:0] m_left  = 5'd0;
	logic       m_kind  = 1'b0;

	rx_t pending_bytes [$];
	rx_t last_byte;
	bit  got_byte;

	int  cycle;
	int  n_bad;
	int  n_sent;
	bit  no_gaps;
	bit  rx_hold_req;

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// Strict window, evaluated wide so nothing wraps
	function automatic bit fits(input logic [TICK_W-1:0] t, input logic [TICK_W-1:0] nom);
		int tt;
		int nn;
		int mm;
		tt = t;
		nn = nom;
		mm = w_margin;
		return (tt + mm > nn) && (tt < nn + mm);
	endfunction

	function automatic void clear_bits();
		m_acc  = 8'h00;
		m_mask = MASK_INIT;
		m_left = 5'd0;
	endfunction

	function automatic void drop_packet();
		m_timer = 1'b0;
		clear_bits();
		m_phase = RX_IDLE;
	endfunction

	// Advance the mirror by one accepted event; queue the byte it completes
	function automatic void decode_edge(input evt_t e);
		logic [TICK_W-1:0] t;
		logic              closes;
		rx_t               r;
		got_byte = 1'b0;
		t = m_timer ? e.elapsed : '0;
		if (e.func) begin
			drop_packet();
			return;
		end
		case (m_phase)
			RX_IDLE: begin
				if (!e.level) begin
					m_timer = 1'b1;
				end else if (fits(t, w_header)) begin
					clear_bits();
					m_phase = RX_HEADER;
				end else begin
					drop_packet();
				end
			end
			RX_HEADER, RX_DATA: begin
				if (!e.level && fits(t, w_space))
					m_phase = RX_SPACE;
				else
					drop_packet();
			end
			default: begin
				// one window wins where the two overlap
				if (!e.level || !(fits(t, w_one) || fits(t, w_zero))) begin
					drop_packet();
					return;
				end
				if (fits(t, w_one))
					m_acc = m_acc | m_mask;
				m_mask = m_mask >> 1;
				if (m_left == 5'd0) begin
					m_kind = m_acc[7];
					m_left = m_kind ? MSG_BITS : SHOT_BITS;
				end
				m_left  = m_left - 5'd1;
				closes  = (m_left == 5'd0);
				m_phase = closes ? RX_IDLE : RX_DATA;
				if (m_mask == 8'h00 || closes) begin
					r.rx_byte    = m_acc;
					r.packet_end = closes;
					r.is_message = m_kind;
					pending_bytes.push_back(r);
					last_byte = r;
					got_byte  = 1'b1;
					m_acc     = 8'h00;
					m_mask    = MASK_INIT;
				end
			end
		endcase
	endfunction

	function automatic void flag_bad(input string what, input int want, input int got);
		n_bad++;
		if (n_bad <= 10)
			$display("mismatch %s at cycle %0d: expected %0h, got %0h", what, cycle, want, got);
	endfunction

	function automatic void match_byte(input rx_t want, input rx_t got);
		if (want.rx_byte !== got.rx_byte)
			flag_bad("rx_byte", want.rx_byte, got.rx_byte);
		if (want.packet_end !== got.packet_end)
			flag_bad("packet_end", want.packet_end, got.packet_end);
		if (want.is_message !== got.is_message)
			flag_bad("is_message", want.is_message, got.is_message);
	endfunction

	// Sample every handshake and register write at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HEADER: w_header = cfg_wdata;
					REG_ONE:    w_one    = cfg_wdata;
					REG_ZERO:   w_zero   = cfg_wdata;
					REG_SPACE:  w_space  = cfg_wdata;
					REG_MARGIN: w_margin = cfg_wdata;
					default:    ;
				endcase
			end
			if (evt_ch.valid && evt_ch.ready)
				decode_edge(evt_ch.payload);
			if (byte_ch.valid && byte_ch.ready) begin
				if (pending_bytes.size() == 0)
					flag_bad("unexpected byte", 0, byte_ch.payload.rx_byte);
				else
					match_byte(pending_bytes.pop_front(), byte_ch.payload);
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle++;
		if (cycle >= CYCLE_LIMIT) begin
			$display("[ir_pulse_width_receiver_unit] ERROR");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = int'($urandom_range(0, 99));
		if (r < 60)
			return 0;
		if (r < 92)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(4, 40));
	endfunction

	// Receiver side: random stalls, plus one long hold-off on request
	initial begin : rx_side
		int n;
		byte_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				byte_ch.ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					byte_ch.ready <= 1'b0;
					repeat (n) @(negedge clk);
				end
				byte_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one beat from a falling edge; return at the falling edge after it is taken
	task automatic send_event(input evt_t e);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		evt_ch.valid   <= 1'b1;
		evt_ch.payload <= e;
		@(posedge clk);
		while (!evt_ch.ready)
			@(posedge clk);
		n_sent++;
		@(negedge clk);
	endtask

	function automatic evt_t noise_event();
		evt_t e;
		e.func    = ($urandom_range(0, 9) == 0);
		e.level   = 1'($urandom_range(0, 1));
		e.elapsed = TICK_W'($urandom_range(0, 65535));
		return e;
	endfunction

	// Send an edge, or with the given chance per mille a random beat instead
	task automatic push_edge(input logic level, input logic [TICK_W-1:0] elapsed,
			input int noise);
		evt_t e;
		e.func    = 1'b0;
		e.level   = level;
		e.elapsed = elapsed;
		if ($urandom_range(0, 999) < noise)
			e = noise_event();
		send_event(e);
	endtask

	// Duration inside the strict window around nom (nom itself if the window is empty), edges picked now and then
	function automatic logic [TICK_W-1:0] pick_len(input logic [TICK_W-1:0] nom);
		int lo;
		int hi;
		int r;
		lo = int'(nom) - int'(w_margin) + 1;
		hi = int'(nom) + int'(w_margin) - 1;
		if (lo < 0)
			lo = 0;
		if (hi > 65535)
			hi = 65535;
		if (lo > hi)
			return nom;
		r = int'($urandom_range(0, 19));
		if (r == 0)
			return TICK_W'(lo);
		if (r == 1)
			return TICK_W'(hi);
		return TICK_W'($urandom_range(hi, lo));
	endfunction

	// Lower valid, wait out every queued byte, then let the pipeline empty
	task automatic drain();
		evt_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic put_reg(input cfg_reg_t idx, input logic [TICK_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	task automatic load_windows(input logic [TICK_W-1:0] header, input logic [TICK_W-1:0] one,
			input logic [TICK_W-1:0] zero, input logic [TICK_W-1:0] space,
			input logic [TICK_W-1:0] margin);
		put_reg(REG_HEADER, header);
		put_reg(REG_ONE, one);
		put_reg(REG_ZERO, zero);
		put_reg(REG_SPACE, space);
		put_reg(REG_MARGIN, margin);
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed packets with random bits, some noise bursts
	task automatic run_phase(input int n_events, input int noise);
		int  stop;
		int  nbits;
		int  k;
		bit  msg;
		bit  b;
		stop = n_sent + n_events;
		while (n_sent < stop) begin
			if ($urandom_range(0, 9) == 0) begin
				k = int'($urandom_range(2, 8));
				repeat (k) send_event(noise_event());
			end else begin
				msg   = 1'($urandom_range(0, 1));
				nbits = msg ? MSG_BITS : SHOT_BITS;
				push_edge(1'b0, TICK_W'($urandom_range(0, 65535)), noise);
				push_edge(1'b1, pick_len(w_header), noise);
				for (int i = 0; i < nbits; i++) begin
					b = (i == 0) ? msg : 1'($urandom_range(0, 1));
					push_edge(1'b0, pick_len(w_space), noise);
					push_edge(1'b1, pick_len(b ? w_one : w_zero), noise);
				end
			end
			// now and then hold the sender until every byte is back
			if ($urandom_range(0, 15) == 0)
				drain();
		end
	endtask

	initial begin
		evt_t ev;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_HEADER;
		cfg_wdata      = '0;
		evt_ch.valid   = 1'b0;
		evt_ch.payload = '0;
		no_gaps        = 1'b0;
		rx_hold_req    = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed edges at reset windows
		for (int i = 0; i < PLAN_ROWS; i++) begin
			ev.func    = PLAN[i].func;
			ev.level   = PLAN[i].level;
			ev.elapsed = PLAN[i].elapsed;
			send_event(ev);
			if (PLAN[i].chk) begin
				if (!got_byte)
					flag_bad("directed byte missing", PLAN[i].want_byte, 0);
				else
					match_byte({PLAN[i].want_byte, PLAN[i].want_end, PLAN[i].want_msg},
						last_byte);
			end
		end
		run_phase(180, 5);

		// Short windows: a gap-free stretch, then a long receiver hold-off
		drain();
		load_windows(16'd40, 16'd20, 16'd10, 16'd10, 16'd3);
		no_gaps = 1'b1;
		run_phase(60, 0);
		no_gaps     = 1'b0;
		rx_hold_req = 1'b1;
		run_phase(100, 5);

		// Overlapping one and zero windows
		drain();
		load_windows(16'd300, 16'd100, 16'd110, 16'd50, 16'd30);
		run_phase(100, 5);

		// Margin above every nominal: lower bounds always hold
		drain();
		load_windows(16'd5, 16'd3, 16'd1, 16'd2, 16'd8);
		run_phase(80, 10);

		// Widest windows
		drain();
		load_windows(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
		run_phase(80, 10);

		// Zero margin: nothing fits
		drain();
		load_windows(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
		run_phase(30, 5);

		// Random windows, then back to reset values
		repeat (2) begin
			drain();
			load_windows(TICK_W'($urandom_range(0, 65535)), TICK_W'($urandom_range(0, 65535)),
				TICK_W'($urandom_range(0, 65535)), TICK_W'($urandom_range(0, 65535)),
				TICK_W'($urandom_range(0, 4000)));
			run_phase(50, 5);
		end
		drain();
		load_windows(HEADER_RST, ONE_RST, ZERO_RST, SPACE_RST, MARGIN_RST);
		run_phase(100, 5);

		drain();
		if (n_bad == 0 && pending_bytes.size() == 0)
			$display("[ir_pulse_width_receiver_unit] OK");
		else
			$display("[ir_pulse_width_receiver_unit] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/irpw_pkg.sv
hw/rtl/irpw_stream_if.sv
hw/rtl/irpw_cfg_regs.sv
hw/rtl/irpw_core.sv
hw/rtl/ir_pulse_width_receiver_unit.sv
test/testbench.sv
